[rtl/core/utf8_stream_validator_defines.svh]
// ---------------------------------------------------------------------------
// UTF-8 stream validator assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ---------------------------------------------------------------------------
`ifndef UTF8_STREAM_VALIDATOR_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_DEFINES_SVH

// Same-cycle implication.
`define U8V_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("utf8_stream_validator: assertion failed");

// Next-cycle implication.
`define U8V_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("utf8_stream_validator: assertion failed");

`endif

[rtl/core/u8v_pkg.sv]
// ---------------------------------------------------------------------------
// UTF-8 stream validator package
// Shared state type and byte classification constants.
// ---------------------------------------------------------------------------
package u8v_pkg;

  // Byte class masks and patterns.
  localparam logic [7:0] AsciiMax   = 8'h7F;
  localparam logic [7:0] Lead2Mask  = 8'hE0;
  localparam logic [7:0] Lead2Pat   = 8'hC0;
  localparam logic [7:0] Lead3Mask  = 8'hF0;
  localparam logic [7:0] Lead3Pat   = 8'hE0;
  localparam logic [7:0] Lead4Mask  = 8'hF8;
  localparam logic [7:0] Lead4Pat   = 8'hF0;
  localparam logic [7:0] ContMask   = 8'hC0;
  localparam logic [7:0] ContPat    = 8'h80;
  localparam logic [7:0] SurrLead   = 8'hED;
  localparam logic [7:0] SurrMask   = 8'hA0;

  // Per-string decoder state.
  typedef struct packed {
    logic [1:0] cnt;       // continuation bytes still owed
    logic       after_ed;  // previous byte was lead 0xED
    logic       failed;    // a failure was seen in this string
  } state_t;

  localparam state_t StateClear = '{cnt: 2'd0, after_ed: 1'b0, failed: 1'b0};

endpackage

[rtl/core/u8v_step.sv]
// ---------------------------------------------------------------------------
// UTF-8 stream validator step logic
// Applies one item to the decoder state and forms the string verdict.
// ---------------------------------------------------------------------------
module u8v_step (
  input  u8v_pkg::state_t st_i,
  input  logic [7:0]      data_byte_i,
  input  logic            has_byte_i,
  input  logic            end_of_string_i,
  output u8v_pkg::state_t st_o,
  output logic            string_valid_o
);

  u8v_pkg::state_t after_byte;

  // Byte check: continuation handling or lead classification.
  always_comb begin
    after_byte = st_i;
    if (has_byte_i && !st_i.failed) begin
      if (st_i.cnt != 2'd0) begin
        if ((st_i.after_ed && ((data_byte_i & u8v_pkg::SurrMask) == u8v_pkg::SurrMask)) ||
            ((data_byte_i & u8v_pkg::ContMask) != u8v_pkg::ContPat)) begin
          after_byte = '{cnt: 2'd0, after_ed: 1'b0, failed: 1'b1};
        end else begin
          after_byte.cnt      = st_i.cnt - 2'd1;
          after_byte.after_ed = 1'b0;
        end
      end else if (data_byte_i <= u8v_pkg::AsciiMax) begin
        after_byte = st_i;
      end else if ((data_byte_i & u8v_pkg::Lead2Mask) == u8v_pkg::Lead2Pat) begin
        after_byte.cnt = 2'd1;
      end else if ((data_byte_i & u8v_pkg::Lead3Mask) == u8v_pkg::Lead3Pat) begin
        after_byte.cnt      = 2'd2;
        after_byte.after_ed = (data_byte_i == u8v_pkg::SurrLead);
      end else if ((data_byte_i & u8v_pkg::Lead4Mask) == u8v_pkg::Lead4Pat) begin
        after_byte.cnt = 2'd3;
      end else begin
        after_byte = '{cnt: 2'd0, after_ed: 1'b0, failed: 1'b1};
      end
    end
  end

  // Verdict covers the byte of this item; the end of a string clears state.
  assign string_valid_o = !after_byte.failed && (after_byte.cnt == 2'd0);
  assign st_o           = end_of_string_i ? u8v_pkg::StateClear : after_byte;

endmodule

[rtl/core/utf8_stream_validator.sv]
// ---------------------------------------------------------------------------
// UTF-8 stream validator
// Checks a byte stream for UTF-8 validity and reports a verdict per string.
// ---------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i / in_ready_o) carries one transaction per
// byte: data_byte_i with has_byte_i set, and end_of_string_i on the last
// transaction of a string. A transaction with has_byte_i low and
// end_of_string_i high is a bare end marker; an empty string is valid.
// Each transaction with end_of_string_i set yields one result transaction
// on the output channel (out_valid_o / out_ready_i) carrying string_valid_o.
// An accepted transaction reaches out_valid_o through the input register
// and then the result register. Throughput is one transaction per cycle
// while in_ready_o is high, set by the state update between them.
// When the receiver stalls, the result register holds its verdict and the
// input register still drains items that produce no result; an end item
// waits there, and in_ready_o drops only when both registers are blocked.
// Reset clears the decoder state and both valid flags; the block is ready
// to accept as soon as reset is released.
// ---------------------------------------------------------------------------
`include "utf8_stream_validator_defines.svh"

module utf8_stream_validator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       has_byte_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       string_valid_o
);

  // Input register.
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_has_q;
  logic       s1_eos_q;
  logic       s1_adv;

  // Decoder state.
  u8v_pkg::state_t st_q, st_d;
  logic            verdict;

  // Result register.
  logic out_valid_q, out_valid_d;
  logic out_data_q;

  // An item leaves the input register when it makes no result or the
  // result register is free or being emptied.
  assign s1_adv     = s1_valid_q && (!s1_eos_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign s1_valid_d = (in_valid_i && in_ready_o) || (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= data_byte_i;
      s1_has_q  <= has_byte_i;
      s1_eos_q  <= end_of_string_i;
    end
  end

  // State update for the item leaving the input register.
  u8v_step u_step (
    .st_i            (st_q),
    .data_byte_i     (s1_byte_q),
    .has_byte_i      (s1_has_q),
    .end_of_string_i (s1_eos_q),
    .st_o            (st_d),
    .string_valid_o  (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= u8v_pkg::StateClear;
    end else if (s1_adv) begin
      st_q <= st_d;
    end
  end

  // Result register.
  assign out_valid_d = (s1_adv && s1_eos_q) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_eos_q) begin
      out_data_q <= verdict;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign string_valid_o = out_data_q;

  // Assertions.
  // A failed string keeps no open sequence and no surrogate mark.
  `U8V_ASSERT_IMPL(a_failed_clean, st_q.failed, (st_q.cnt == 2'd0) && !st_q.after_ed)
  // The 0xED mark only stands right after a three-byte lead.
  `U8V_ASSERT_IMPL(a_ed_after_lead, st_q.after_ed, st_q.cnt == 2'd2)
  // An end item leaving the input register always lands a result.
  `U8V_ASSERT_NEXT(a_end_gives_result, s1_adv && s1_eos_q, out_valid_q)

endmodule
